// File: sv/gfm_pkg.sv
// Shared types and constants of the GF(2^m) multiplier.
package gfm_pkg;

    // Widest field the datapath types can carry
    localparam int unsigned FIELD_MAX_W = 32;

    // Configuration register indexes (word address paddr[2])
    localparam logic REG_DEGREE = 1'b0;
    localparam logic REG_POLY   = 1'b1;

    // Register widths and reset values
    localparam int unsigned DEGREE_W = 5;
    localparam int unsigned POLY_W   = 21;
    localparam logic [DEGREE_W-1:0] DEGREE_RST = 5'd8;
    localparam logic [POLY_W-1:0]   POLY_RST   = 21'd369;

    // Port field width
    localparam int unsigned OPND_W = 20;

    // Field description handed to every pipeline stage
    typedef struct packed {
        logic [4:0]             msb;   // m-1, position of the top element bit
        logic [FIELD_MAX_W-1:0] low;   // (1<<m)-1
        logic [FIELD_MAX_W-1:0] red;   // reduction polynomial, low m bits
    } field_cfg_t;

endpackage

// File: sv/gf2m_multiplier_top.sv
// Top level of the pipelined GF(2^m) polynomial-basis multiplier.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------
//  input    | s_valid / s_ready      | s_operand_a[19:0], s_operand_b[19:0]
//  result   | m_valid / m_ready      | m_product[19:0]
//  config   | psel penable pwrite    | paddr[2:0], pwdata / prdata[31:0]
//
// One request per cycle sustained while m_ready is high; each request passes
// through NUM_ST registered stages (4 at MAX_DEGREE = 20) of shift-and-reduce,
// each doing STEPS = ceil(MAX_DEGREE/4) steps of the bit-serial product.
// Synchronous active-low reset clears the stage valid bits and loads the
// register defaults (m = 8, poly = 0x171). A stall at m_ready backs up
// stage by stage; no request is dropped or repeated.
module gf2m_multiplier_top #(
    parameter int unsigned MAX_DEGREE = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [19:0] s_operand_a,
    input  logic [19:0] s_operand_b,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [19:0] m_product,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned W      = MAX_DEGREE;
    localparam int unsigned STEPS  = (MAX_DEGREE + 3) / 4;
    localparam int unsigned NUM_ST = (MAX_DEGREE + STEPS - 1) / STEPS;
    localparam int unsigned AW     = NUM_ST * STEPS;
    localparam int unsigned FW     = gfm_pkg::OPND_W;
    localparam int unsigned MX     = gfm_pkg::FIELD_MAX_W;

    logic [gfm_pkg::DEGREE_W-1:0] degree_reg;
    logic [gfm_pkg::POLY_W-1:0]   poly_reg;
    logic                         wr_en;
    logic [5:0]                   m_eff;
    logic [MX:0]                  low_wide;
    gfm_pkg::field_cfg_t          cfg;

    // Configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= gfm_pkg::DEGREE_RST;
            poly_reg   <= gfm_pkg::POLY_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                gfm_pkg::REG_DEGREE: degree_reg <= pwdata[gfm_pkg::DEGREE_W-1:0];
                gfm_pkg::REG_POLY:   poly_reg   <= pwdata[gfm_pkg::POLY_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        unique case (paddr[2])
            gfm_pkg::REG_DEGREE: prdata = {{(32 - gfm_pkg::DEGREE_W){1'b0}}, degree_reg};
            gfm_pkg::REG_POLY:   prdata = {{(32 - gfm_pkg::POLY_W){1'b0}}, poly_reg};
            default:             prdata = '0;
        endcase
    end

    // Effective degree clamped to [2, MAX_DEGREE], and its masks
    always_comb begin
        m_eff = {1'b0, degree_reg};
        if (m_eff < 6'd2) begin
            m_eff = 6'd2;
        end
        if (m_eff > 6'(MAX_DEGREE)) begin
            m_eff = 6'(MAX_DEGREE);
        end
        low_wide = ({{MX{1'b0}}, 1'b1} << m_eff) - {{MX{1'b0}}, 1'b1};
        cfg.low  = low_wide[MX-1:0];
        cfg.red  = {{(MX - gfm_pkg::POLY_W){1'b0}}, poly_reg} & low_wide[MX-1:0];
        cfg.msb  = 5'(m_eff - 6'd1);
    end

    // Stage chain
    logic          vld_w [NUM_ST+1];
    logic          rdy_w [NUM_ST+1];
    logic [AW-1:0] a_w   [NUM_ST+1];
    logic [W-1:0]  acc_w [NUM_ST+1];
    logic [W-1:0]  cur_w [NUM_ST+1];

    logic [FW+W-1:0]  a_ext, b_ext;
    logic [AW+W-1:0]  a_pad;
    logic [FW+W-1:0]  p_ext;

    // Entry: operands cut to m bits
    always_comb begin
        a_ext = {{W{1'b0}}, s_operand_a};
        b_ext = {{W{1'b0}}, s_operand_b};
        a_pad = {{AW{1'b0}}, a_ext[W-1:0] & cfg.low[W-1:0]};
    end

    assign vld_w[0] = s_valid;
    assign s_ready  = rdy_w[0];
    assign a_w[0]   = a_pad[AW-1:0];
    assign acc_w[0] = '0;
    assign cur_w[0] = b_ext[W-1:0] & cfg.low[W-1:0];

    for (genvar k = 0; k < NUM_ST; k++) begin : g_st
        gfm_stage #(
            .W     (W),
            .STEPS (STEPS),
            .AW    (AW)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cfg       (cfg),
            .in_valid  (vld_w[k]),
            .in_ready  (rdy_w[k]),
            .a_in      (a_w[k]),
            .acc_in    (acc_w[k]),
            .cur_in    (cur_w[k]),
            .out_valid (vld_w[k+1]),
            .out_ready (rdy_w[k+1]),
            .a_out     (a_w[k+1]),
            .acc_out   (acc_w[k+1]),
            .cur_out   (cur_w[k+1])
        );
    end

    // Exit: product widened or cut to the port width
    assign rdy_w[NUM_ST] = m_ready;
    assign m_valid       = vld_w[NUM_ST];
    assign p_ext         = {{FW{1'b0}}, acc_w[NUM_ST]};
    assign m_product     = p_ext[FW-1:0];

endmodule

// File: sv/gfm_stage.sv
// One pipeline stage of the multiplier: STEPS shift-and-reduce steps.
module gfm_stage #(
    parameter int unsigned W     = 20,
    parameter int unsigned STEPS = 5,
    parameter int unsigned AW    = 20
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  gfm_pkg::field_cfg_t cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [AW-1:0]       a_in,
    input  logic [W-1:0]        acc_in,
    input  logic [W-1:0]        cur_in,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [AW-1:0]       a_out,
    output logic [W-1:0]        acc_out,
    output logic [W-1:0]        cur_out
);

    localparam int unsigned IW = (W > 2) ? $clog2(W) : 1;

    logic          vld_reg, vld_next;
    logic [AW-1:0] a_reg, a_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  cur_reg, cur_next;
    logic [W-1:0]  low;
    logic [W-1:0]  red;
    logic [IW-1:0] msb;

    assign low = cfg.low[W-1:0];
    assign red = cfg.red[W-1:0];
    assign msb = cfg.msb[IW-1:0];

    // Stage takes a new request when empty or when its content moves on
    assign in_ready = !vld_reg || out_ready;
    assign vld_next = in_ready ? in_valid : vld_reg;

    // STEPS dependent steps: accumulate, then multiply cur by alpha
    always_comb begin
        logic [W-1:0] acc_t;
        logic [W-1:0] cur_t;
        logic         top;
        acc_t = acc_in;
        cur_t = cur_in;
        for (int j = 0; j < STEPS; j++) begin
            if (a_in[j]) begin
                acc_t = acc_t ^ cur_t;
            end
            top   = cur_t[msb];
            cur_t = ((cur_t << 1) & low) ^ (top ? red : '0);
        end
        acc_next = acc_t;
        cur_next = cur_t;
        a_next   = a_in >> STEPS;
    end

    // Valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Payload, loaded only on an accepted request
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            a_reg   <= a_next;
            acc_reg <= acc_next;
            cur_reg <= cur_next;
        end
    end

    assign out_valid = vld_reg;
    assign a_out     = a_reg;
    assign acc_out   = acc_reg;
    assign cur_out   = cur_reg;

endmodule

// File: tb/gf2m_multiplier_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the GF(2^m) multiplier: random operands, APB field setup.
module gf2m_multiplier_top_tb;

    localparam int unsigned OPND_W   = gfm_pkg::OPND_W;
    localparam int unsigned DEGREE_W = gfm_pkg::DEGREE_W;
    localparam int unsigned POLY_W   = gfm_pkg::POLY_W;

    localparam int CLK_HALF        = 10;
    localparam int FIELD_DEG_MAX   = 20;
    localparam int SETTLE_CYCLES   = 16;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int NUM_PHASES      = 14;
    localparam int ITEMS_PER_PHASE = 140;
    localparam logic [OPND_W-1:0] ALL_ONES = '1;

    // One multiply request and the product it should give
    typedef struct {
        logic [OPND_W-1:0] op_a;
        logic [OPND_W-1:0] op_b;
        logic [OPND_W-1:0] product;
    } mul_req_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [OPND_W-1:0] s_operand_a = '0;
    logic [OPND_W-1:0] s_operand_b = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [OPND_W-1:0] m_product;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [2:0]        paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;

    mul_req_t req_q[$];      // operand pairs waiting to be sent
    mul_req_t product_q[$];  // accepted requests, oldest first

    // Local copy of the field registers
    logic [DEGREE_W-1:0] cur_degree = gfm_pkg::DEGREE_RST;
    logic [POLY_W-1:0]   cur_poly   = gfm_pkg::POLY_RST;

    int unsigned reqs_queued  = 0;
    int unsigned results_seen = 0;
    int unsigned err_cnt      = 0;
    int unsigned src_gap      = 0;
    int unsigned sink_gap     = 0;
    int unsigned cycle_cnt    = 0;
    bit          no_idle      = 1'b0;

    gf2m_multiplier_top #(.MAX_DEGREE(FIELD_DEG_MAX)) dut (.*);

    always #CLK_HALF aclk = ~aclk;

    // Degree actually used: register clamped to 2..MAX_DEGREE
    function automatic int eff_degree(input logic [DEGREE_W-1:0] deg);
        if (deg < 2) return 2;
        if (deg > FIELD_DEG_MAX) return FIELD_DEG_MAX;
        return int'(deg);
    endfunction

    // Shift-and-add product; reduce whenever the shifted term reaches x^m
    function automatic logic [OPND_W-1:0] gf_mul(input logic [OPND_W-1:0] a,
                                                  input logic [OPND_W-1:0] b,
                                                  input logic [DEGREE_W-1:0] deg,
                                                  input logic [POLY_W-1:0] poly);
        int          m;
        logic [31:0] low, top, red, acc, cur, am;
        m   = eff_degree(deg);
        low = (32'd1 << m) - 32'd1;
        top = 32'd1 << m;
        red = 32'(poly) & low;
        acc = '0;
        cur = 32'(b) & low;
        am  = 32'(a) & low;
        for (int i = 0; i < m; i++) begin
            if (am[i]) acc ^= cur;
            cur = cur << 1;
            if ((cur & top) != 0) cur = (cur ^ red) & low;
        end
        return acc[OPND_W-1:0];
    endfunction

    // Operand mix: half full-width noise, plus in-field values and edge patterns
    function automatic logic [OPND_W-1:0] rand_operand(input int m);
        logic [OPND_W-1:0] raw;
        logic [OPND_W-1:0] field_mask;
        raw        = OPND_W'($urandom);
        field_mask = ALL_ONES >> (OPND_W - m);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return raw;
            5, 6: return raw & field_mask;
            7: begin
                raw = '0;
                raw[$urandom_range(0, m - 1)] = 1'b1;
                return raw;
            end
            8: return field_mask;
            default: return $urandom_range(0, 1) ? ALL_ONES : (raw & ~field_mask);
        endcase
    endfunction

    task automatic log_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR: %s", msg);
    endtask

    task automatic queue_op(input logic [OPND_W-1:0] a, input logic [OPND_W-1:0] b);
        req_q.push_back('{a, b, '0});
        reqs_queued++;
    endtask

    // APB write: setup cycle, then access until pready
    task automatic apb_write(input logic reg_sel, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_field(input logic [DEGREE_W-1:0] deg, input logic [POLY_W-1:0] poly);
        apb_write(gfm_pkg::REG_DEGREE, 32'(deg));
        cur_degree = deg;
        apb_write(gfm_pkg::REG_POLY, 32'(poly));
        cur_poly = poly;
    endtask

    // Hold until every product is back, then let the pipeline settle
    task automatic wait_drained();
        while (results_seen != reqs_queued) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Request driver with random idle bursts after a request
    always @(posedge aclk) begin
        mul_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                product_q.push_back('{s_operand_a, s_operand_b,
                                      gf_mul(s_operand_a, s_operand_b, cur_degree, cur_poly)});
            end
            if (!s_valid || s_ready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (req_q.size() != 0) begin
                    nxt = req_q.pop_front();
                    s_valid     <= 1'b1;
                    s_operand_a <= nxt.op_a;
                    s_operand_b <= nxt.op_b;
                    if (!no_idle && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 19);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and back-pressure
    always @(posedge aclk) begin
        mul_req_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (product_q.size() == 0) begin
                log_error($sformatf("unexpected product 0x%05h", m_product));
            end else begin
                want = product_q.pop_front();
                if (m_product !== want.product)
                    log_error($sformatf(
                        "a=0x%05h b=0x%05h m=%0d poly=0x%06h: expected 0x%05h, got 0x%05h",
                        want.op_a, want.op_b, eff_degree(cur_degree), cur_poly,
                        want.product, m_product));
            end
        end
        if (sink_gap != 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            sink_gap = $urandom_range(0, 18);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("TIMEOUT after %0d cycles", cycle_cnt);
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus: one field setting per phase, drained before each change
    initial begin
        int                  m;
        logic [DEGREE_W-1:0] deg;
        logic [POLY_W-1:0]   poly;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            no_idle = (ph == NUM_PHASES - 1);
            case (ph)
                0: begin deg = gfm_pkg::DEGREE_RST; poly = gfm_pkg::POLY_RST; end  // defaults
                1: begin deg = 5'd2;       poly = 21'h000007;  end  // smallest field, high poly bits
                2: begin deg = 5'd0;       poly = 21'h1FFFFF;  end  // degree below range
                3: begin deg = 5'd1;       poly = 21'h000000;  end
                4: begin deg = 5'd20;      poly = 21'h000009;  end  // largest field
                5: begin deg = 5'd31;      poly = 21'h1FFFFF;  end  // degree above range
                6: begin deg = 5'd21;      poly = 21'h100009;  end
                7: begin deg = 5'd4;       poly = 21'h000013;  end
                default: begin
                    deg  = DEGREE_W'($urandom_range(2, FIELD_DEG_MAX));
                    poly = POLY_W'($urandom);
                end
            endcase
            if (ph != 0) set_field(deg, poly);
            m = eff_degree(deg);

            // Directed corners: all ones, and the top field bit squared
            if (ph < 8) begin
                queue_op(ALL_ONES, ALL_ONES);
                queue_op((ALL_ONES >> (OPND_W - m)) ^ (ALL_ONES >> (OPND_W - m + 1)),
                         (ALL_ONES >> (OPND_W - m)) ^ (ALL_ONES >> (OPND_W - m + 1)));
            end
            if (ph == 0) begin
                queue_op('0, '0);
                queue_op(20'h00001, 20'h000AB);
                queue_op(20'hFFF00, 20'h12345);  // only bits above the field in a
                queue_op(20'h00002, 20'h00080);  // alpha times alpha^7 wraps
            end

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                queue_op(rand_operand(m), rand_operand(m));
            wait_drained();
        end

        if (product_q.size() != 0)
            log_error($sformatf("%0d products never arrived", product_q.size()));
        if (err_cnt == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
sv/gfm_pkg.sv
sv/gfm_stage.sv
sv/gf2m_multiplier_top.sv
tb/gf2m_multiplier_top_tb.sv
